[rtl/core/downsample_2x2_reduce_assert.svh]
`ifndef DOWNSAMPLE_2X2_REDUCE_ASSERT_SVH
`define DOWNSAMPLE_2X2_REDUCE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define DS2X2_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ds2x2 same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define DS2X2_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ds2x2 next-cycle check failed");

`endif

[rtl/core/ds2x2_pkg.sv]
package ds2x2_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 3;
  localparam int CHAN_W       = 8;
  localparam int PIX_W        = MAX_CHANNELS * CHAN_W;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 12;
  localparam int CNT_W        = 2;
  localparam int CFG_W        = 13;
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W       = POS_W - 1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [CNT_W-1:0] RESET_CHANS  = 2'd3;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_REDUCE_MODE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MAX      = 2'd0,
    MODE_MEAN     = 2'd1,
    MODE_TOP_LEFT = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef logic [MAX_CHANNELS-1:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    logic                    fire;
    logic                    last;
    logic [MAX_CHANNELS-1:0] lane_en;
  } emit_t;

endpackage

[rtl/core/downsample_2x2_reduce.sv]
// channel  dir  signals                      content
// s_*      in   tvalid tready tdata[23:0]    input pixel
// m_*      out  tvalid tready tdata tlast    reduced pixel, tlast = frame end
// cfg_*    in   we index[1:0] data[12:0]     register write
//
// One input beat per cycle while s_tready is high; a result appears in the
// cycle after the odd-row, odd-column beat that completes its 2x2 block.
// The line store is two single-port banks; the pair is read on the held
// even-column beat of the odd row, so the completing beat needs no read.
// rst is synchronous; the line store is not cleared and needs no pass.
// s_tready drops only while a result is held and m_tready is low.
module downsample_2x2_reduce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ds2x2_pkg::PIX_W-1:0]  s_tdata,  // chan_a, chan_b, chan_c
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ds2x2_pkg::PIX_W-1:0]  m_tdata,  // out_a, out_b, out_c
  output logic                         m_tlast,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [ds2x2_pkg::CFG_W-1:0]  cfg_data
);
  import ds2x2_pkg::*;

  `include "downsample_2x2_reduce_assert.svh"

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [CNT_W-1:0] channel_count;
  mode_t            reduce_mode;

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  pix_t             held;
  pix_t             pix;
  pix_t             rd_even;
  pix_t             rd_odd;
  pix_t             lane_res;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] used_w;
  logic [DIM_W-1:0] used_h;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] row_ext;
  logic [CNT_W-1:0] nch;
  logic             s_acc;
  logic             col_last;
  logic             row_last;
  logic             emit;
  emit_t            emit_info;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_WIDTH;
      image_height  <= RESET_HEIGHT;
      channel_count <= RESET_CHANS;
      reduce_mode   <= MODE_MAX;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        REG_REDUCE_MODE:   reduce_mode   <= mode_t'(cfg_data[1:0]);
      endcase
    end
  end

  always_comb begin
    pix = pix_t'(s_tdata);
    if (image_width < DIM_W'(2)) begin
      w_eff = DIM_W'(2);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < DIM_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    nch      = (channel_count == '0) ? CNT_W'(1) : channel_count;
    used_w   = {w_eff[DIM_W-1:1], 1'b0};
    used_h   = {h_eff[DIM_W-1:1], 1'b0};
    col_ext  = {1'b0, col};
    row_ext  = {1'b0, row};
    col_last = DIM_W'(col_ext + DIM_W'(1)) >= w_eff;
    row_last = DIM_W'(row_ext + DIM_W'(1)) >= h_eff;
    emit     = row[0] && col[0] && (col_ext < used_w) && (row_ext < used_h);
    s_tready = !m_tvalid || m_tready;
    s_acc    = s_tvalid && s_tready;

    emit_info.fire = s_acc && emit;
    emit_info.last = (row_ext == DIM_W'(used_h - DIM_W'(1)))
                  && (col_ext == DIM_W'(used_w - DIM_W'(1)));
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      emit_info.lane_en[k] = CNT_W'(k) < nch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      held <= '0;
    end else if (s_acc) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : POS_W'(row + POS_W'(1));
      end else begin
        col <= POS_W'(col + POS_W'(1));
      end
      if (row[0] && !col[0]) begin
        held <= pix;
      end
    end
  end

  ds2x2_line_store u_store (
    .clk     (clk),
    .we      (s_acc && !row[0]),
    .wr_odd  (col[0]),
    .waddr   (col[POS_W-1:1]),
    .wdata   (pix),
    .re      (s_acc && row[0] && !col[0]),
    .raddr   (col[POS_W-1:1]),
    .rd_even (rd_even),
    .rd_odd  (rd_odd)
  );

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
    ds2x2_lane u_lane (
      .mode   (reduce_mode),
      .tl     (rd_even[k]),
      .tr     (rd_odd[k]),
      .bl     (held[k]),
      .br     (pix[k]),
      .result (lane_res[k])
    );
  end

  ds2x2_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit_info),
    .lane_res (lane_res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `DS2X2_ASSERT_IMPL(emit_on_odd_pair, s_acc && emit, row[0] && col[0])
  `DS2X2_ASSERT_NEXT(emit_fills_output, s_acc && emit, m_tvalid)
  `DS2X2_ASSERT_NEXT(row_end_clears_column, s_acc && col_last, col == '0)

endmodule

[rtl/core/ds2x2_line_store.sv]
module ds2x2_line_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     wr_odd,
  input  logic [ds2x2_pkg::ADDR_W-1:0] waddr,
  input  ds2x2_pkg::pix_t          wdata,
  input  logic                     re,
  input  logic [ds2x2_pkg::ADDR_W-1:0] raddr,
  output ds2x2_pkg::pix_t          rd_even,
  output ds2x2_pkg::pix_t          rd_odd
);
  import ds2x2_pkg::*;

  // even and odd columns in separate banks, one pair per address
  pix_t mem_even [STORE_DEPTH];
  pix_t mem_odd  [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we && !wr_odd) begin
      mem_even[waddr] <= wdata;
    end
    if (re) begin
      rd_even <= mem_even[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we && wr_odd) begin
      mem_odd[waddr] <= wdata;
    end
    if (re) begin
      rd_odd <= mem_odd[raddr];
    end
  end

endmodule

[rtl/core/ds2x2_lane.sv]
module ds2x2_lane (
  input  ds2x2_pkg::mode_t            mode,
  input  logic [ds2x2_pkg::CHAN_W-1:0] tl,
  input  logic [ds2x2_pkg::CHAN_W-1:0] tr,
  input  logic [ds2x2_pkg::CHAN_W-1:0] bl,
  input  logic [ds2x2_pkg::CHAN_W-1:0] br,
  output logic [ds2x2_pkg::CHAN_W-1:0] result
);
  import ds2x2_pkg::*;

  logic [CHAN_W-1:0] m0;
  logic [CHAN_W-1:0] m1;
  logic [CHAN_W-1:0] max_v;
  logic [CHAN_W+1:0] sum;
  logic [CHAN_W+1:0] rounded;

  always_comb begin
    m0      = (tl >= tr) ? tl : tr;
    m1      = (bl >= br) ? bl : br;
    max_v   = (m0 >= m1) ? m0 : m1;
    sum     = (CHAN_W+2)'(tl) + (CHAN_W+2)'(tr) + (CHAN_W+2)'(bl) + (CHAN_W+2)'(br);
    rounded = sum + (CHAN_W+2)'(2);
    unique case (mode)
      MODE_MAX:  result = max_v;
      MODE_MEAN: result = rounded[CHAN_W+1:2];
      default:   result = tl;
    endcase
  end

endmodule

[rtl/core/ds2x2_merge.sv]
module ds2x2_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  ds2x2_pkg::emit_t      emit,
  input  ds2x2_pkg::pix_t       lane_res,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [ds2x2_pkg::PIX_W-1:0] m_tdata,
  output logic                  m_tlast
);
  import ds2x2_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.fire) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        m_tdata[k*CHAN_W +: CHAN_W] <= emit.lane_en[k] ? lane_res[k] : '0;
      end
      m_tlast <= emit.last;
    end
  end

endmodule

[tb/ds2x2_checker.sv]
module ds2x2_checker
  import ds2x2_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // chan_a, chan_b, chan_c
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [PIX_W-1:0]  m_tdata,   // out_a, out_b, out_c
  input  logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pix_t px;
    logic frame_end;
  } reduced_pix_t;

  reduced_pix_t     due_px[$];
  pix_t             even_row [MAX_WIDTH];
  pix_t             held_px;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [CNT_W-1:0] chans_reg;
  mode_t            mode_reg;

  task automatic report_mismatch(input string what);
    $display("%0t ns ds2x2 mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] reduce_block(mode_t m, logic [CHAN_W-1:0] tl,
                                                     logic [CHAN_W-1:0] tr,
                                                     logic [CHAN_W-1:0] bl,
                                                     logic [CHAN_W-1:0] br);
    logic [CHAN_W-1:0] upper;
    logic [CHAN_W-1:0] lower;
    logic [CHAN_W+1:0] sum;
    case (m)
      MODE_MAX: begin
        upper = (tl >= tr) ? tl : tr;
        lower = (bl >= br) ? bl : br;
        return (upper >= lower) ? upper : lower;
      end
      MODE_MEAN: begin
        sum = (CHAN_W+2)'(tl) + (CHAN_W+2)'(tr) + (CHAN_W+2)'(bl)
            + (CHAN_W+2)'(br) + (CHAN_W+2)'(2);
        return sum[CHAN_W+1:2];
      end
      default: return tl;
    endcase
  endfunction

  always @(posedge clk) begin
    int unsigned  w;
    int unsigned  h;
    int unsigned  nch;
    int unsigned  used_w;
    int unsigned  used_h;
    pix_t         px;
    pix_t         tl;
    pix_t         tr;
    pix_t         got;
    reduced_pix_t want;
    if (rst) begin
      due_px.delete();
      held_px    = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      chans_reg  = RESET_CHANS;
      mode_reg   = MODE_MAX;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_IMAGE_WIDTH:   width_reg  = cfg_data;
          REG_IMAGE_HEIGHT:  height_reg = cfg_data;
          REG_CHANNEL_COUNT: chans_reg  = cfg_data[CNT_W-1:0];
          REG_REDUCE_MODE:   mode_reg   = mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end

      // input beat: store even rows, hold odd-row even column, emit on odd column
      if (s_tvalid && s_tready) begin
        w      = clamp_dim(width_reg, 2, MAX_WIDTH);
        h      = clamp_dim(height_reg, 2, MAX_HEIGHT);
        nch    = clamp_dim(chans_reg, 1, MAX_CHANNELS);
        used_w = w & ~1;
        used_h = h & ~1;
        px     = s_tdata;
        if (!row_pos[0]) begin
          if (col_pos < MAX_WIDTH) even_row[col_pos] = px;
        end else if (!col_pos[0]) begin
          held_px = px;
        end else if (col_pos < used_w && row_pos < used_h) begin
          tl = even_row[col_pos-1];
          tr = even_row[col_pos];
          for (int k = 0; k < MAX_CHANNELS; k++)
            want.px[k] = (k < nch) ?
                         reduce_block(mode_reg, tl[k], tr[k], held_px[k], px[k]) : '0;
          want.frame_end = (row_pos == used_h - 1) && (col_pos == used_w - 1);
          due_px.push_back(want);
        end
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end

      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (due_px.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h frame_end %b", got, m_tlast));
        end else begin
          want = due_px.pop_front();
          for (int k = 0; k < MAX_CHANNELS; k++)
            if (got[k] !== want.px[k])
              report_mismatch($sformatf("out channel %0d got %h want %h", k, got[k],
                                        want.px[k]));
          if (m_tlast !== want.frame_end)
            report_mismatch($sformatf("frame_end got %b want %b", m_tlast, want.frame_end));
        end
      end
    end
    pending = due_px.size();
  end

endmodule

[tb/tb.sv]
module tb;
  import ds2x2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 650;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic             clk;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [PIX_W-1:0] m_tdata;
  logic             m_tlast;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  int          errors;
  int          pending;
  int          cycle_cnt = 0;
  int          src_idle  = 33;
  int          snk_idle  = 62;
  int          pixels_sent;
  int unsigned frame_w;
  int unsigned frame_h;

  downsample_2x2_reduce dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ds2x2_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_idle);

  // entered and left at a falling edge; s_tvalid stays high for a back-to-back beat
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pix_t rand_pixel();
    pix_t px;
    for (int k = 0; k < MAX_CHANNELS; k++)
      case ($urandom_range(5))
        0:       px[k] = 8'h00;
        1:       px[k] = 8'hFF;
        default: px[k] = 8'($urandom);
      endcase
    return px;
  endfunction

  task automatic send_rows(input int unsigned rows);
    repeat (rows * frame_w) begin
      send_pixel(rand_pixel());
      pixels_sent++;
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] chans, input logic [CFG_W-1:0] mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= chans;
    @(negedge clk);
    cfg_index <= REG_REDUCE_MODE;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_we  <= 1'b0;
    frame_w = (w < 2) ? 2 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    frame_h = (h < 2) ? 2 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
  endtask

  task automatic configure_random();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    w = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9));
    h = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 7));
    configure(w, h, {11'($urandom), 2'($urandom_range(3))},
              {11'($urandom), 2'($urandom_range(3))});
  endtask

  initial begin
    int unsigned rows_done;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // max over extremes, 2x1 output
    configure(13'd4, 13'd2, 13'd3, CFG_W'(MODE_MAX));
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h7F8001);
    send_pixel(24'h0001FE);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF7F80);
    send_pixel(24'h55FE01);

    // mean rounding, odd width and height, channel count zero
    configure(13'd3, 13'd3, 13'd0, CFG_W'(MODE_MEAN));
    send_pixel(24'h000001);
    send_pixel(24'h000001);
    send_pixel(24'h1234FF);
    send_pixel(24'h000000);
    send_pixel(24'h00FF00);
    send_pixel(24'hABCDEF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h808080);

    // spare mode acts as top-left
    configure(13'd2, 13'd2, 13'd2, CFG_W'(MODE_SPARE));
    send_pixel(24'h112233);
    send_pixel(24'h445566);
    send_pixel(24'h778899);
    send_pixel(24'hAABBCC);

    configure(13'd2, 13'd2, 13'd3, CFG_W'(MODE_TOP_LEFT));
    send_pixel(24'h010203);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);

    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      if (pixels_sent < RANDOM_PIXELS / 3) begin
        src_idle = 33;
        snk_idle = 62;
      end else if (pixels_sent < 2 * RANDOM_PIXELS / 3) begin
        src_idle = 62;
        snk_idle = 33;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      configure_random();
      if ($urandom_range(3) == 0 && frame_h >= 3) begin
        // reconfigure at the start of an even row, then finish that frame
        rows_done = 2 * $urandom_range(1, (frame_h - 1) / 2);
        send_rows(rows_done);
        configure_random();
        send_rows((rows_done + 1 >= frame_h) ? 1 : frame_h - rows_done);
      end else begin
        send_rows(frame_h * $urandom_range(1, 3));
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
